// ===== rtl/core/nrsp_pkg.sv =====
// Shared constants, codes and control types of the nearest ray/sphere pick.
`timescale 1ns / 1ps

package nrsp_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ID_BITS_DEF    = 16;

    // Width of the ray parameter t and of the distance cap.
    localparam int T_BITS = 31;
    localparam logic [T_BITS-1:0] T_MAX = {T_BITS{1'b1}};

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ORG_X = 3'd0;
    localparam cfg_idx_t CFG_ORG_Y = 3'd1;
    localparam cfg_idx_t CFG_ORG_Z = 3'd2;
    localparam cfg_idx_t CFG_DIR_X = 3'd3;
    localparam cfg_idx_t CFG_DIR_Y = 3'd4;
    localparam cfg_idx_t CFG_DIR_Z = 3'd5;
    localparam cfg_idx_t CFG_CAP   = 3'd6;

    // Product jobs of the serial multiplier, in issue order.
    typedef logic [3:0] job_t;
    localparam job_t JOB_DD_X = 4'd0;
    localparam job_t JOB_DD_Y = 4'd1;
    localparam job_t JOB_DD_Z = 4'd2;
    localparam job_t JOB_DW_X = 4'd3;
    localparam job_t JOB_DW_Y = 4'd4;
    localparam job_t JOB_DW_Z = 4'd5;
    localparam job_t JOB_WW_X = 4'd6;
    localparam job_t JOB_WW_Y = 4'd7;
    localparam job_t JOB_WW_Z = 4'd8;
    localparam job_t JOB_RR   = 4'd9;
    localparam job_t JOB_BB   = 4'd10;
    localparam job_t JOB_AC   = 4'd11;

    // Numerator choice for the divider.
    typedef enum logic [1:0] {
        NUM_B_MINUS_S = 2'd0,
        NUM_B_PLUS_S  = 2'd1,
        NUM_S_MINUS_B = 2'd2
    } num_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        logic     mul_step;
        logic     acc;
        logic     fold;
        logic     sq_start;
        logic     sq_step;
        logic     div_start;
        logic     div_step;
        logic     take;
        logic     miss;
        logic     update;
        logic     emit;
        job_t     job;
        num_sel_t num_sel;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic sq_done;
        logic div_done;
        logic a_zero;
        logic disc_neg;
        logic bneg;
        logic b_gt_s;
        logic s_gt_b;
        logic q_zero;
        logic last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/nrsp_ctrl.sv =====
// Controller state machine sequencing the pick datapath.
`timescale 1ns / 1ps

module nrsp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  nrsp_pkg::stat_t stat,
    output nrsp_pkg::cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_MSTART = 12'b0000_0000_0010,
        S_MUL    = 12'b0000_0000_0100,
        S_ACC    = 12'b0000_0000_1000,
        S_FOLD   = 12'b0000_0001_0000,
        S_CHECK  = 12'b0000_0010_0000,
        S_SQRT   = 12'b0000_0100_0000,
        S_PICK   = 12'b0000_1000_0000,
        S_DIV    = 12'b0001_0000_0000,
        S_DIVEND = 12'b0010_0000_0000,
        S_UPDATE = 12'b0100_0000_0000,
        S_EMIT   = 12'b1000_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    nrsp_pkg::job_t   job_reg, job_next;
    logic             first_reg, first_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        first_next  = first_reg;
        cmd         = '0;
        cmd.job     = job_reg;
        cmd.num_sel = nrsp_pkg::NUM_B_PLUS_S;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    job_next   = nrsp_pkg::JOB_DD_X;
                    state_next = S_MSTART;
                end
            end
            S_MSTART:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                if (stat.mul_done)
                    state_next = S_ACC;
                else
                    cmd.mul_step = 1'b1;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (job_reg == nrsp_pkg::JOB_RR)
                begin
                    job_next   = nrsp_pkg::JOB_BB;
                    state_next = S_FOLD;
                end
                else if (job_reg == nrsp_pkg::JOB_AC)
                    state_next = S_CHECK;
                else
                begin
                    job_next   = nrsp_pkg::job_t'(job_reg + 1'b1);
                    state_next = S_MSTART;
                end
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (stat.a_zero)
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_UPDATE;
                end
                else
                    state_next = S_MSTART;
            end
            S_CHECK:
            begin
                if (stat.disc_neg)
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.sq_start = 1'b1;
                    state_next   = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (stat.sq_done)
                    state_next = S_PICK;
                else
                    cmd.sq_step = 1'b1;
            end
            S_PICK:
            begin
                // near root first, far root as fallback
                if (stat.bneg && stat.b_gt_s)
                begin
                    cmd.div_start = 1'b1;
                    cmd.num_sel   = nrsp_pkg::NUM_B_MINUS_S;
                    first_next    = 1'b1;
                    state_next    = S_DIV;
                end
                else if (stat.bneg || stat.s_gt_b)
                begin
                    cmd.div_start = 1'b1;
                    cmd.num_sel   = stat.bneg ? nrsp_pkg::NUM_B_PLUS_S
                                              : nrsp_pkg::NUM_S_MINUS_B;
                    first_next    = 1'b0;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_DIVEND;
                else
                    cmd.div_step = 1'b1;
            end
            S_DIVEND:
            begin
                if (first_reg && stat.q_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.num_sel   = nrsp_pkg::NUM_B_PLUS_S;
                    first_next    = 1'b0;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.take   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= nrsp_pkg::JOB_DD_X;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== rtl/core/nrsp_datapath.sv =====
// Datapath: serial multiplier, square root and divider, running best and result register.
`timescale 1ns / 1ps

module nrsp_datapath #(
    parameter int COORD_BITS = nrsp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = nrsp_pkg::FRAC_BITS_DEF,
    parameter int ID_BITS    = nrsp_pkg::ID_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nrsp_pkg::cmd_t                   cmd,
    output nrsp_pkg::stat_t                  stat,
    input  logic [2:0][COORD_BITS-1:0]       org,
    input  logic [2:0][COORD_BITS-1:0]       dir,
    input  logic [nrsp_pkg::T_BITS-1:0]      cap,
    input  logic [COORD_BITS-1:0]            center_x,
    input  logic [COORD_BITS-1:0]            center_y,
    input  logic [COORD_BITS-1:0]            center_z,
    input  logic [COORD_BITS-2:0]            sphere_radius,
    input  logic [ID_BITS-1:0]               sphere_id,
    input  logic                             last_sphere,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic                             hit_found,
    output logic [ID_BITS-1:0]               nearest_id,
    output logic [nrsp_pkg::T_BITS-1:0]      nearest_t
);

    localparam int CW   = COORD_BITS;
    localparam int TB   = nrsp_pkg::T_BITS;
    localparam int AW   = 2 * CW;          // a = d.d
    localparam int BW   = 2 * CW + 1;      // |b|
    localparam int CMW  = 2 * CW + 2;      // |c|
    localparam int YW   = 2 * CW + 2;      // multiplier operand
    localparam int PW   = 4 * CW + 2;      // product
    localparam int DSW  = 4 * CW + 4;      // signed discriminant
    localparam int SW   = 2 * CW + 2;      // square root
    localparam int QW   = 2 * SW;          // root working width
    localparam int NW   = 2 * CW + 3;      // numerator
    localparam int RW   = (NW + FRAC_BITS > AW + TB) ? NW + FRAC_BITS : AW + TB;
    localparam int CNTW = $clog2(TB + 1);

    logic [2:0][CW-1:0] cen;
    assign cen = {center_z, center_y, center_x};

    // operand registers
    logic [2:0][CW-1:0]      dm_reg, dm_next, wm_reg, wm_next;
    logic [2:0]              dneg_reg, dneg_next, wneg_reg, wneg_next;
    logic [CW-2:0]           r_reg, r_next;
    logic [ID_BITS-1:0]      id_reg, id_next;
    logic                    last_reg, last_next;
    // multiplier
    logic [PW-1:0]           mx_reg, mx_next, p_reg, p_next;
    logic [YW-1:0]           my_reg, my_next;
    // quadratic terms
    logic [AW-1:0]           a_reg, a_next;
    logic signed [BW:0]      b_reg, b_next;
    logic signed [CMW:0]     c_reg, c_next;
    logic [BW-1:0]           bmag_reg, bmag_next;
    logic                    bneg_reg, bneg_next;
    logic [CMW-1:0]          cmag_reg, cmag_next;
    logic                    cneg_reg, cneg_next;
    logic signed [DSW-1:0]   disc_reg, disc_next;
    // square root
    logic [QW-1:0]           sv_reg, sv_next, sres_reg, sres_next, sbit_reg, sbit_next;
    // divider
    logic [RW-1:0]           rem_reg, rem_next, dv_reg, dv_next;
    logic [TB-1:0]           q_reg, q_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [TB-1:0]           cand_reg, cand_next;
    // running best and result
    logic [TB-1:0]           best_t_reg, best_t_next;
    logic [ID_BITS-1:0]      best_id_reg, best_id_next;
    logic                    any_reg, any_next;
    logic                    ov_reg, ov_next;
    logic                    oh_reg, oh_next;
    logic [ID_BITS-1:0]      oid_reg, oid_next;
    logic [TB-1:0]           ot_reg, ot_next;

    // combinational helpers
    logic signed [CW:0]      w_s;
    logic [CW:0]             w_abs;
    logic [1:0]              kk;
    logic [PW-1:0]           op_x;
    logic [YW-1:0]           op_y;
    logic signed [BW:0]      pb, b_abs;
    logic signed [CMW:0]     pc, c_abs;
    logic signed [DSW-1:0]   pd;
    logic [QW-1:0]           trial;
    logic [SW-1:0]           s_val;
    logic [NW-1:0]           bmag_e, s_e, num;
    logic [RW-1:0]           ns, lim;
    logic                    ge;
    logic                    better;

    assign s_val  = sres_reg[SW-1:0];
    assign bmag_e = NW'(bmag_reg);
    assign s_e    = NW'(s_val);
    assign trial  = sres_reg + sbit_reg;
    assign pb     = $signed({1'b0, p_reg[BW-1:0]});
    assign pc     = $signed({1'b0, p_reg[CMW-1:0]});
    assign pd     = $signed({2'b00, p_reg});
    assign b_abs  = b_reg[BW] ? -b_reg : b_reg;
    assign c_abs  = c_reg[CMW] ? -c_reg : c_reg;
    assign ge     = (dv_reg <= rem_reg);
    assign better = (cand_reg != '0) && (cand_reg < cap) && (cand_reg < best_t_reg);

    always_comb
    begin
        case (cmd.num_sel)
            nrsp_pkg::NUM_B_MINUS_S: num = bmag_e - s_e;
            nrsp_pkg::NUM_S_MINUS_B: num = s_e - bmag_e;
            default:                 num = bmag_e + s_e;
        endcase
        ns  = RW'(num) << FRAC_BITS;
        lim = RW'(a_reg) << TB;
    end

    // operand selection per product job
    always_comb
    begin
        case (cmd.job)
            nrsp_pkg::JOB_DD_X, nrsp_pkg::JOB_DW_X, nrsp_pkg::JOB_WW_X: kk = 2'd0;
            nrsp_pkg::JOB_DD_Y, nrsp_pkg::JOB_DW_Y, nrsp_pkg::JOB_WW_Y: kk = 2'd1;
            default:                                                     kk = 2'd2;
        endcase
        case (cmd.job)
            nrsp_pkg::JOB_DD_X, nrsp_pkg::JOB_DD_Y, nrsp_pkg::JOB_DD_Z:
            begin
                op_x = PW'(dm_reg[kk]);
                op_y = YW'(dm_reg[kk]);
            end
            nrsp_pkg::JOB_DW_X, nrsp_pkg::JOB_DW_Y, nrsp_pkg::JOB_DW_Z:
            begin
                op_x = PW'(dm_reg[kk]);
                op_y = YW'(wm_reg[kk]);
            end
            nrsp_pkg::JOB_WW_X, nrsp_pkg::JOB_WW_Y, nrsp_pkg::JOB_WW_Z:
            begin
                op_x = PW'(wm_reg[kk]);
                op_y = YW'(wm_reg[kk]);
            end
            nrsp_pkg::JOB_RR:
            begin
                op_x = PW'(r_reg);
                op_y = YW'(r_reg);
            end
            nrsp_pkg::JOB_BB:
            begin
                op_x = PW'(bmag_reg);
                op_y = YW'(bmag_reg);
            end
            default:
            begin
                op_x = PW'(a_reg);
                op_y = YW'(cmag_reg);
            end
        endcase
    end

    always_comb
    begin
        dm_next = dm_reg;   wm_next = wm_reg;   dneg_next = dneg_reg; wneg_next = wneg_reg;
        r_next = r_reg;     id_next = id_reg;   last_next = last_reg;
        mx_next = mx_reg;   my_next = my_reg;   p_next = p_reg;
        a_next = a_reg;     b_next = b_reg;     c_next = c_reg;
        bmag_next = bmag_reg; bneg_next = bneg_reg; cmag_next = cmag_reg; cneg_next = cneg_reg;
        disc_next = disc_reg;
        sv_next = sv_reg;   sres_next = sres_reg; sbit_next = sbit_reg;
        rem_next = rem_reg; dv_next = dv_reg;   q_next = q_reg;     cnt_next = cnt_reg;
        cand_next = cand_reg;
        best_t_next = best_t_reg; best_id_next = best_id_reg; any_next = any_reg;
        oh_next = oh_reg;   oid_next = oid_reg; ot_next = ot_reg;
        ov_next = ov_reg & ~out_ready;
        w_s   = '0;
        w_abs = '0;

        if (cmd.load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w_s          = $signed({org[k][CW-1], org[k]}) - $signed({cen[k][CW-1], cen[k]});
                w_abs        = w_s[CW] ? (~w_s + 1'b1) : w_s;
                dneg_next[k] = dir[k][CW-1];
                dm_next[k]   = dir[k][CW-1] ? (~dir[k] + 1'b1) : dir[k];
                wneg_next[k] = w_s[CW];
                wm_next[k]   = w_abs[CW-1:0];
            end
            r_next    = sphere_radius;
            id_next   = sphere_id;
            last_next = last_sphere;
            a_next    = '0;
            b_next    = '0;
            c_next    = '0;
        end

        if (cmd.mul_start)
        begin
            mx_next = op_x;
            my_next = op_y;
            p_next  = '0;
        end

        // one multiplier bit per cycle
        if (cmd.mul_step)
        begin
            if (my_reg[0])
                p_next = p_reg + mx_reg;
            mx_next = mx_reg << 1;
            my_next = my_reg >> 1;
        end

        if (cmd.acc)
        begin
            case (cmd.job)
                nrsp_pkg::JOB_DD_X, nrsp_pkg::JOB_DD_Y, nrsp_pkg::JOB_DD_Z:
                    a_next = a_reg + p_reg[AW-1:0];
                nrsp_pkg::JOB_DW_X, nrsp_pkg::JOB_DW_Y, nrsp_pkg::JOB_DW_Z:
                    b_next = (dneg_reg[kk] ^ wneg_reg[kk]) ? b_reg - pb : b_reg + pb;
                nrsp_pkg::JOB_WW_X, nrsp_pkg::JOB_WW_Y, nrsp_pkg::JOB_WW_Z:
                    c_next = c_reg + pc;
                nrsp_pkg::JOB_RR:
                    c_next = c_reg - pc;
                nrsp_pkg::JOB_BB:
                    disc_next = pd;
                default:
                    disc_next = cneg_reg ? disc_reg + pd : disc_reg - pd;
            endcase
        end

        if (cmd.fold)
        begin
            bneg_next = b_reg[BW];
            bmag_next = b_abs[BW-1:0];
            cneg_next = c_reg[CMW];
            cmag_next = c_abs[CMW-1:0];
        end

        if (cmd.sq_start)
        begin
            sv_next   = disc_reg[QW-1:0];
            sres_next = '0;
            sbit_next = QW'(1) << (QW - 2);
        end

        // one root bit per cycle
        if (cmd.sq_step)
        begin
            if (sv_reg >= trial)
            begin
                sv_next   = sv_reg - trial;
                sres_next = (sres_reg >> 1) + sbit_reg;
            end
            else
                sres_next = sres_reg >> 1;
            sbit_next = sbit_reg >> 2;
        end

        if (cmd.div_start)
        begin
            if (ns >= lim)
            begin
                q_next   = nrsp_pkg::T_MAX;
                cnt_next = '0;
            end
            else
            begin
                q_next   = '0;
                cnt_next = CNTW'(TB);
            end
            rem_next = ns;
            dv_next  = RW'(a_reg) << (TB - 1);
        end

        // one quotient bit per cycle
        if (cmd.div_step)
        begin
            if (ge)
                rem_next = rem_reg - dv_reg;
            q_next   = {q_reg[TB-2:0], ge};
            dv_next  = dv_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.take)
            cand_next = q_reg;
        if (cmd.miss)
            cand_next = '0;

        if (cmd.update && better)
        begin
            best_t_next  = cand_reg;
            best_id_next = id_reg;
            any_next     = 1'b1;
        end

        if (cmd.emit)
        begin
            ov_next      = 1'b1;
            oh_next      = any_reg;
            oid_next     = any_reg ? best_id_reg : '0;
            ot_next      = any_reg ? best_t_reg : '0;
            best_t_next  = cap;
            best_id_next = '0;
            any_next     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        dm_reg <= dm_next;   wm_reg <= wm_next;   dneg_reg <= dneg_next; wneg_reg <= wneg_next;
        r_reg <= r_next;     id_reg <= id_next;   last_reg <= last_next;
        mx_reg <= mx_next;   my_reg <= my_next;   p_reg <= p_next;
        a_reg <= a_next;     b_reg <= b_next;     c_reg <= c_next;
        bmag_reg <= bmag_next; bneg_reg <= bneg_next;
        cmag_reg <= cmag_next; cneg_reg <= cneg_next;
        disc_reg <= disc_next;
        sv_reg <= sv_next;   sres_reg <= sres_next; sbit_reg <= sbit_next;
        rem_reg <= rem_next; dv_reg <= dv_next;   q_reg <= q_next;     cnt_reg <= cnt_next;
        cand_reg <= cand_next;
        oh_reg <= oh_next;   oid_reg <= oid_next; ot_reg <= ot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_t_reg  <= nrsp_pkg::T_MAX;
            best_id_reg <= '0;
            any_reg     <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            best_t_reg  <= best_t_next;
            best_id_reg <= best_id_next;
            any_reg     <= any_next;
            ov_reg      <= ov_next;
        end
    end

    assign stat.mul_done = (my_reg == '0);
    assign stat.sq_done  = (sbit_reg == '0);
    assign stat.div_done = (cnt_reg == '0);
    assign stat.a_zero   = (a_reg == '0);
    assign stat.disc_neg = disc_reg[DSW-1];
    assign stat.bneg     = bneg_reg;
    assign stat.b_gt_s   = (bmag_e > s_e);
    assign stat.s_gt_b   = (s_e > bmag_e);
    assign stat.q_zero   = (q_reg == '0);
    assign stat.last     = last_reg;
    assign stat.out_free = ~ov_reg | out_ready;

    assign out_valid  = ov_reg;
    assign hit_found  = oh_reg;
    assign nearest_id = oid_reg;
    assign nearest_t  = ot_reg;

endmodule

// ===== rtl/core/nearest_ray_sphere_pick.sv =====
// Top level of the nearest ray/sphere pick: ray registers, controller and datapath.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// input    | in        | in_valid/in_ready  | center_x/y/z, sphere_radius, sphere_id, last_sphere
// result   | out       | out_valid/out_ready| hit_found, nearest_id, nearest_t
// config   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One sphere at a time. Each sphere takes a load, then up to twelve products on a
// radix-2 serial multiplier (each ending once the multiplier operand is shifted
// out), 2*COORD_BITS+2 square root steps, and one or two divisions of up to 31
// steps; the serial multiplier takes most of the time spent on a sphere.
// Reset clears the ray to zero and the distance cap and running best to the
// maximum t. A finished result waits in the output register while the next
// sphere is taken; only the closing sphere of a pick waits for that register.
// Config transfers are always taken (cfg_ready is tied high).

module nearest_ray_sphere_pick #(
    parameter int COORD_BITS = nrsp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = nrsp_pkg::FRAC_BITS_DEF,
    parameter int ID_BITS    = nrsp_pkg::ID_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [COORD_BITS-1:0]               center_x,
    input  logic [COORD_BITS-1:0]               center_y,
    input  logic [COORD_BITS-1:0]               center_z,
    input  logic [COORD_BITS-2:0]               sphere_radius,
    input  logic [ID_BITS-1:0]                  sphere_id,
    input  logic                                last_sphere,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit_found,
    output logic [ID_BITS-1:0]                  nearest_id,
    output logic [nrsp_pkg::T_BITS-1:0]         nearest_t,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  nrsp_pkg::cfg_idx_t                  cfg_index,
    input  logic [((COORD_BITS > nrsp_pkg::T_BITS) ? COORD_BITS : nrsp_pkg::T_BITS)-1:0]
                                                cfg_data
);

    logic [2:0][COORD_BITS-1:0]  org_reg, dir_reg;
    logic [nrsp_pkg::T_BITS-1:0] cap_reg;
    nrsp_pkg::cmd_t              cmd;
    nrsp_pkg::stat_t             stat;
    logic                        cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    // Ray and cap registers; unknown indexes drop the transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg <= '0;
            dir_reg <= '0;
            cap_reg <= nrsp_pkg::T_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nrsp_pkg::CFG_ORG_X: org_reg[0] <= cfg_data[COORD_BITS-1:0];
                nrsp_pkg::CFG_ORG_Y: org_reg[1] <= cfg_data[COORD_BITS-1:0];
                nrsp_pkg::CFG_ORG_Z: org_reg[2] <= cfg_data[COORD_BITS-1:0];
                nrsp_pkg::CFG_DIR_X: dir_reg[0] <= cfg_data[COORD_BITS-1:0];
                nrsp_pkg::CFG_DIR_Y: dir_reg[1] <= cfg_data[COORD_BITS-1:0];
                nrsp_pkg::CFG_DIR_Z: dir_reg[2] <= cfg_data[COORD_BITS-1:0];
                nrsp_pkg::CFG_CAP:   cap_reg    <= cfg_data[nrsp_pkg::T_BITS-1:0];
                default:             cap_reg    <= cap_reg;
            endcase
        end
    end

    nrsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nrsp_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ID_BITS    (ID_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .org           (org_reg),
        .dir           (dir_reg),
        .cap           (cap_reg),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .sphere_id     (sphere_id),
        .last_sphere   (last_sphere),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .hit_found     (hit_found),
        .nearest_id    (nearest_id),
        .nearest_t     (nearest_t)
    );

endmodule

// ===== tb/nearest_ray_sphere_pick_tb.sv =====
// Testbench for the nearest ray/sphere pick: random and directed spheres against a predictor.
`timescale 1ns / 1ps

module nearest_ray_sphere_pick_tb;

    localparam int HALF_PERIOD = 2;
    // Allow for the worst sphere plus result stalls; let any sphere in flight finish.
    localparam int SETTLE_CYCLES = 1500;

    typedef struct {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] radius;
        logic [15:0] id;
        logic        last;
    } sphere_item_t;

    typedef struct {
        logic        hit;
        logic [15:0] id;
        logic [30:0] t;
    } pick_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] sphere_radius;
    logic [15:0] sphere_id;
    logic last_sphere;
    logic out_valid;
    logic out_ready;
    logic hit_found;
    logic [15:0] nearest_id;
    logic [30:0] nearest_t;
    logic cfg_valid;
    logic cfg_ready;
    nrsp_pkg::cfg_idx_t cfg_index;
    logic [31:0] cfg_data;

    nearest_ray_sphere_pick dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .center_x(center_x),
        .center_y(center_y),
        .center_z(center_z),
        .sphere_radius(sphere_radius),
        .sphere_id(sphere_id),
        .last_sphere(last_sphere),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit_found(hit_found),
        .nearest_id(nearest_id),
        .nearest_t(nearest_t),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor copy of the ray registers and of the running best.
    logic signed [31:0] ray_org[3];
    logic signed [31:0] ray_dir[3];
    logic [30:0] cap_t;
    logic [30:0] best_t;
    logic [15:0] best_id;
    logic        any_hit;

    sphere_item_t sphere_q[$];
    pick_result_t pick_q[$];
    sphere_item_t cur_sphere;
    int gap_left;
    int stall_left;
    bit no_gaps;
    int err_count;

    always #(HALF_PERIOD) clk = ~clk;

    // Scale (num << F) / a to t, saturating at the largest t.
    function automatic logic [30:0] t_ratio(logic signed [259:0] num, logic signed [259:0] a);
        logic signed [259:0] ns;
        logic signed [259:0] q;
        ns = num <<< 16;
        if (ns >= (a <<< 31))
            return nrsp_pkg::T_MAX;
        q = ns / a;
        return q[30:0];
    endfunction

    // Nearest positive t of the ray against one sphere; 0 means a miss.
    function automatic logic [30:0] hit_distance(sphere_item_t s);
        logic signed [259:0] d;
        logic signed [259:0] w;
        logic signed [259:0] a;
        logic signed [259:0] b;
        logic signed [259:0] c;
        logic signed [259:0] rr;
        logic signed [259:0] disc;
        logic signed [259:0] root;
        logic signed [259:0] cand;
        logic signed [259:0] bmag;
        logic signed [31:0] ctr[3];
        logic [30:0] t;
        logic bneg;
        ctr[0] = s.cx;
        ctr[1] = s.cy;
        ctr[2] = s.cz;
        a = 0;
        b = 0;
        c = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = ray_dir[k];
            w = ray_org[k];
            w = w - ctr[k];
            a = a + d * d;
            b = b + d * w;
            c = c + w * w;
        end
        rr = s.radius;
        c = c - rr * rr;
        if (a == 0)
            return '0;
        disc = b * b - a * c;
        if (disc < 0)
            return '0;
        root = 0;
        for (int i = 127; i >= 0; i--)
        begin
            cand = root | (260'sd1 <<< i);
            if (cand * cand <= disc)
                root = cand;
        end
        bneg = b < 0;
        bmag = bneg ? -b : b;
        if (bneg && bmag > root)
        begin
            t = t_ratio(bmag - root, a);
            if (t != 0)
                return t;
        end
        if (bneg)
            return t_ratio(bmag + root, a);
        if (root > bmag)
            return t_ratio(root - bmag, a);
        return '0;
    endfunction

    // Fold one accepted sphere into the running best; close the pick on the last one.
    task automatic track_sphere(sphere_item_t s);
        logic [30:0] t;
        pick_result_t r;
        t = hit_distance(s);
        if (t != 0 && t < cap_t && t < best_t)
        begin
            best_t = t;
            best_id = s.id;
            any_hit = 1'b1;
        end
        if (s.last)
        begin
            r.hit = any_hit;
            r.id = any_hit ? best_id : '0;
            r.t = any_hit ? best_t : '0;
            pick_q = {pick_q, r};
            best_t = cap_t;
            best_id = '0;
            any_hit = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
        err_count++;
    endtask

    // Input driver: hold the payload until the transfer, then draw a gap.
    always @(posedge clk)
    begin
        logic next_valid;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                track_sphere(cur_sphere);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (sphere_q.size() > 0)
                begin
                    cur_sphere = sphere_q.pop_front();
                    center_x <= cur_sphere.cx;
                    center_y <= cur_sphere.cy;
                    center_z <= cur_sphere.cz;
                    sphere_radius <= cur_sphere.radius;
                    sphere_id <= cur_sphere.id;
                    last_sphere <= cur_sphere.last;
                    next_valid = 1'b1;
                    gap_left = no_gaps ? 0 : $urandom_range(0, 11);
                end
            end
            in_valid <= next_valid;
        end
    end

    // Result monitor: check each transfer against the oldest pick, stall at random.
    always @(posedge clk)
    begin
        pick_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pick_q.size() == 0)
                    report_mismatch("result with no pick open", 32'(nearest_t), 32'd0);
                else
                begin
                    want = pick_q.pop_front();
                    if (hit_found !== want.hit)
                        report_mismatch("hit_found", 32'(hit_found), 32'(want.hit));
                    if (nearest_id !== want.id)
                        report_mismatch("nearest_id", 32'(nearest_id), 32'(want.id));
                    if (nearest_t !== want.t)
                        report_mismatch("nearest_t", 32'(nearest_t), 32'(want.t));
                end
                stall_left = no_gaps ? 0 : $urandom_range(0, 11);
            end
            else if (stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0);
        end
    end

    task automatic write_reg(nrsp_pkg::cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            nrsp_pkg::CFG_ORG_X: ray_org[0] = value;
            nrsp_pkg::CFG_ORG_Y: ray_org[1] = value;
            nrsp_pkg::CFG_ORG_Z: ray_org[2] = value;
            nrsp_pkg::CFG_DIR_X: ray_dir[0] = value;
            nrsp_pkg::CFG_DIR_Y: ray_dir[1] = value;
            nrsp_pkg::CFG_DIR_Z: ray_dir[2] = value;
            nrsp_pkg::CFG_CAP:   cap_t = value[30:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [31:0] cap);
        write_reg(nrsp_pkg::CFG_ORG_X, ox);
        write_reg(nrsp_pkg::CFG_ORG_Y, oy);
        write_reg(nrsp_pkg::CFG_ORG_Z, oz);
        write_reg(nrsp_pkg::CFG_DIR_X, dx);
        write_reg(nrsp_pkg::CFG_DIR_Y, dy);
        write_reg(nrsp_pkg::CFG_DIR_Z, dz);
        write_reg(nrsp_pkg::CFG_CAP, cap);
    endtask

    // Wait for the pick to drain, then let the block fall idle.
    task automatic drain();
        while (sphere_q.size() > 0 || in_valid || pick_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [30:0] r, logic [15:0] id, logic last);
        sphere_item_t s;
        s.cx = x;
        s.cy = y;
        s.cz = z;
        s.radius = r;
        s.id = id;
        s.last = last;
        sphere_q = {sphere_q, s};
    endtask

    // Sphere centered near the ray at a random distance; mostly in front, some behind.
    function automatic logic [31:0] along(int k, longint tc, int jitter);
        longint v;
        v = longint'(ray_org[k]) + ((tc * longint'(ray_dir[k])) >>> 16) + jitter;
        return v[31:0];
    endfunction

    task automatic add_random_pick();
        int n;
        int kind;
        longint tc;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 19);
            tc = (kind < 3) ? -longint'($urandom_range(0, 20 << 16))
                            : longint'($urandom_range(0, 24 << 16));
            if (kind >= 17)
                add_sphere($urandom, $urandom, $urandom, 31'($urandom), 16'($urandom),
                           i == n - 1);
            else
                add_sphere(along(0, tc, int'($urandom_range(0, 1 << 17)) - (1 << 16)),
                           along(1, tc, int'($urandom_range(0, 1 << 17)) - (1 << 16)),
                           along(2, tc, int'($urandom_range(0, 1 << 17)) - (1 << 16)),
                           31'($urandom_range(0, 1 << 19)), 16'($urandom), i == n - 1);
        end
    endtask

    function automatic logic [31:0] small_coord(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        center_x = '0;
        center_y = '0;
        center_z = '0;
        sphere_radius = '0;
        sphere_id = '0;
        last_sphere = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = nrsp_pkg::CFG_ORG_X;
        cfg_data = '0;
        gap_left = 0;
        stall_left = 0;
        no_gaps = 1'b0;
        err_count = 0;
        for (int k = 0; k < 3; k++)
        begin
            ray_org[k] = '0;
            ray_dir[k] = '0;
        end
        cap_t = nrsp_pkg::T_MAX;
        best_t = nrsp_pkg::T_MAX;
        best_id = '0;
        any_hit = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset ray has zero direction: every sphere misses.
        add_sphere(32'h0, 32'h0, 32'h0, 31'h7FFFFFFF, 16'hFFFF, 1'b1);
        drain();

        // Ray along +x from the origin.
        set_ray(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'(nrsp_pkg::T_MAX));
        write_reg(nrsp_pkg::cfg_idx_t'(7), 32'hDEAD_BEEF);   // unmapped index, drop it
        add_sphere(32'h0005_0000, 32'h0, 32'h0, 31'h0001_0000, 16'h0001, 1'b0);
        add_sphere(32'h0005_0000, 32'h0, 32'h0, 31'h0001_0000, 16'h0002, 1'b0); // tie
        add_sphere(32'h0003_0000, 32'h0009_0000, 32'h0, 31'h0001_0000, 16'h0003, 1'b0);
        add_sphere(32'hFFFB_0000, 32'h0, 32'h0, 31'h0001_0000, 16'h0004, 1'b0); // behind
        add_sphere(32'h0000_8000, 32'h0, 32'h0, 31'h0002_0000, 16'h0005, 1'b1); // inside
        add_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h0, 1'b0);
        add_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 16'hFFFF, 1'b0);
        add_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h0, 16'hA5A5, 1'b1);
        add_sphere(32'h0, 32'h0, 32'h0, 31'h0, 16'h5A5A, 1'b1);                 // grazing point
        drain();

        // Tiny direction against a far sphere: t saturates and never passes the cap.
        set_ray(32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'(nrsp_pkg::T_MAX));
        add_sphere(32'h7000_0000, 32'h0, 32'h0, 31'h0001_0000, 16'h0010, 1'b1);
        drain();

        // Cap of zero rejects everything; a short cap cuts the far sphere.
        set_ray(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        add_sphere(32'h0005_0000, 32'h0, 32'h0, 31'h0001_0000, 16'h0020, 1'b1);
        drain();
        write_reg(nrsp_pkg::CFG_CAP, 32'h0006_0000);
        add_sphere(32'h0005_0000, 32'h0, 32'h0, 31'h0001_0000, 16'h0021, 1'b0);
        add_sphere(32'h0009_0000, 32'h0, 32'h0, 31'h0001_0000, 16'h0022, 1'b0);
        add_sphere(32'h0000_0000, 32'h0, 32'h0, 31'h0000_0000, 16'h0023, 1'b1);
        drain();

        // Random rays, each phase ending with every pick drained.
        for (int phase = 0; phase < 7; phase++)
        begin
            no_gaps = (phase == 2);
            if (phase == 6)
                set_ray(32'h8000_0000, 32'h7FFF_FFFF, $urandom,
                        32'h7FFF_FFFF, 32'h8000_0000, $urandom, 32'(nrsp_pkg::T_MAX));
            else
                set_ray(small_coord(1 << 20), small_coord(1 << 20), small_coord(1 << 20),
                        small_coord(1 << 17), small_coord(1 << 17), small_coord(1 << 17),
                        (phase % 3 == 0) ? 32'(nrsp_pkg::T_MAX)
                                         : 32'($urandom_range(1 << 16, 30 << 16)));
            while (sphere_q.size() < 210)
                add_random_pick();
            drain();
        end

        if (err_count == 0)
            $display("nearest_ray_sphere_pick: match");
        else
            $display("nearest_ray_sphere_pick: mismatch");
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("nearest_ray_sphere_pick: mismatch");
        $finish;
    end

endmodule

// ===== nearest_ray_sphere_pick.f =====
rtl/core/nrsp_pkg.sv
rtl/core/nrsp_ctrl.sv
rtl/core/nrsp_datapath.sv
rtl/core/nearest_ray_sphere_pick.sv
tb/nearest_ray_sphere_pick_tb.sv
